/* hdl/u8sd_pkg.sv */
// u8sd_pkg: shared types, constants and the byte-window parse function of the
// UTF-8 style stream decoder. No dependencies.
package u8sd_pkg;

  localparam int unsigned Depth = 14;
  localparam int unsigned Win = 7;

  localparam logic [0:0] CFG_FLAGS = 1'd0;
  localparam logic [0:0] CFG_BASE  = 1'd1;

  localparam int unsigned FLG_SURR  = 0;
  localparam int unsigned FLG_NONCH = 1;
  localparam int unsigned FLG_ESC   = 2;
  localparam int unsigned FLG_NMIN  = 3;
  localparam int unsigned FLG_ZERO  = 4;

  localparam logic [20:0] BASE_RST = 21'h00EF00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] code_point;
    logic [3:0]  bytes_used;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_P1,
    S_P2,
    S_COMMIT,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic load;
    logic cap_p1;
    logic cap_r1;
    logic cap_r2;
    logic commit;
    logic flush;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic p1_stop;
    logic p1_pair;
    logic p2_undec;
    logic held_v;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic        undec;
    logic [31:0] val;
    logic [2:0]  size;
  } parse_t;

  function automatic parse_t parse(input logic [Win-1:0][7:0] w, input logic [2:0] avail,
                                   input logic fin, input logic [4:0] flags,
                                   input logic [20:0] base);
    parse_t      r;
    logic [31:0] rune;
    logic [31:0] minv;
    logic [31:0] base32;
    logic [31:0] off;
    logic [31:0] errv;
    logic [2:0]  extra;
    logic        bad;
    r.undec = 1'b0;
    r.val   = '0;
    r.size  = '0;
    rune    = '0;
    minv    = '0;
    extra   = '0;
    bad     = 1'b0;
    base32  = {11'd0, base};
    errv    = base32 + {24'd0, w[0]};
    if (avail == 3'd0) begin
      r.undec = !fin;
    end else begin
      if (w[0] < 8'h80) begin
        rune = {24'd0, w[0]};
      end else if (w[0] < 8'hC0) begin
        bad = 1'b1;
      end else if (w[0] < 8'hE0) begin
        rune = {27'd0, w[0][4:0]}; extra = 3'd1; minv = 32'h80;
      end else if (w[0] < 8'hF0) begin
        rune = {28'd0, w[0][3:0]}; extra = 3'd2; minv = 32'h800;
      end else if (w[0] < 8'hF8) begin
        rune = {29'd0, w[0][2:0]}; extra = 3'd3; minv = 32'h10000;
      end else if (w[0] < 8'hFC) begin
        rune = {30'd0, w[0][1:0]}; extra = 3'd4; minv = 32'h200000;
      end else if (w[0] < 8'hFE) begin
        rune = {31'd0, w[0][0]}; extra = 3'd5; minv = 32'h4000000;
      end else if (w[0] < 8'hFF) begin
        extra = 3'd6; minv = 32'h80000000;
      end else begin
        bad = 1'b1;
      end
      for (int i = 1; i < Win; i++) begin
        if (!bad && 3'(i) <= extra) begin
          if (3'(i) >= avail) begin
            r.undec = !fin;
            bad = 1'b1;
          end else if (w[i][7:6] != 2'b10 || rune[31:26] != 6'd0) begin
            bad = 1'b1;
          end else begin
            rune = {rune[25:0], w[i][5:0]};
          end
        end
      end
      off = rune - base32;
      if (!bad) begin
        if ((rune >= base32 && off < 32'd256 && flags[FLG_ESC])
            || (rune < minv && !flags[FLG_NMIN]
                && !(rune == 32'd0 && flags[FLG_ZERO] && extra == 3'd1))
            || ((rune >= 32'h110000 || rune[15:0] >= 16'hFFFE) && !flags[FLG_NONCH])) begin
          bad = 1'b1;
        end
      end
      if (bad) begin
        r.val  = errv;
        r.size = 3'd1;
      end else begin
        r.val  = rune;
        r.size = 3'd1 + extra;
      end
    end
    return r;
  endfunction

endpackage

/* hdl/u8sd_dp.sv */
// u8sd_dp: pending byte buffer, parse logic, result holding and output register.
// Depends on u8sd_pkg.
module u8sd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [20:0]         cfg_data_i,
  input  u8sd_pkg::in_item_t  in_item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output u8sd_pkg::out_item_t out_item_o,
  input  u8sd_pkg::dp_cmd_t   cmd_i,
  output u8sd_pkg::dp_sts_t   sts_o
);

  logic [u8sd_pkg::Depth-1:0][7:0] buf_q, buf_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        fin_q;
  logic [4:0]  flags_q;
  logic [20:0] base_q;
  logic [31:0] v1_q;
  logic [2:0]  s1_q;
  logic [31:0] res_val_q;
  logic [3:0]  res_used_q;
  logic [31:0] held_val_q;
  logic [3:0]  held_used_q;
  logic        held_v_q;
  u8sd_pkg::out_item_t out_q;
  logic        out_v_q;

  logic [u8sd_pkg::Win-1:0][7:0] win0, win2;
  logic [2:0]  avail0, avail2;
  logic [3:0]  rem;
  logic [3:0]  sidx;
  u8sd_pkg::parse_t p1, p2;
  logic [31:0] errl;
  logic        p1_hi, p1_lo, p2_lo;
  logic [31:0] r1_val;
  logic [3:0]  r1_used;
  logic [31:0] r2_val;
  logic [3:0]  r2_used;
  logic        out_take;
  logic [4:0]  src;

  always_comb begin
    for (int k = 0; k < u8sd_pkg::Win; k++) begin
      win0[k] = buf_q[k];
      sidx    = 4'(s1_q) + 4'(k);
      win2[k] = (sidx < 4'(u8sd_pkg::Depth)) ? buf_q[sidx] : 8'd0;
    end
    avail0 = (cnt_q >= 4'd7) ? 3'd7 : cnt_q[2:0];
    rem    = cnt_q - 4'(s1_q);
    avail2 = (rem >= 4'd7) ? 3'd7 : rem[2:0];
  end

  assign p1   = u8sd_pkg::parse(win0, avail0, fin_q, flags_q, base_q);
  assign p2   = u8sd_pkg::parse(win2, avail2, fin_q, flags_q, base_q);
  assign errl = {11'd0, base_q} + {24'd0, buf_q[0]};

  assign p1_hi = p1.val >= 32'hD800 && p1.val <= 32'hDBFF;
  assign p1_lo = p1.val >= 32'hDC00 && p1.val <= 32'hDFFF;
  assign p2_lo = p2.val >= 32'hDC00 && p2.val <= 32'hDFFF;

  always_comb begin
    if ((p1_hi || p1_lo) && !flags_q[u8sd_pkg::FLG_NONCH]) begin
      r1_val  = errl;
      r1_used = 4'd1;
    end else begin
      r1_val  = p1.val;
      r1_used = 4'(p1.size);
    end
    if (p2_lo) begin
      r2_val  = 32'h10000 + {12'd0, v1_q[9:0], 10'd0} + {22'd0, p2.val[9:0]};
      r2_used = 4'(s1_q) + 4'(p2.size);
    end else begin
      r2_val  = errl;
      r2_used = 4'd1;
    end
  end

  assign sts_o.p1_stop  = (cnt_q == 4'd0) || p1.undec;
  assign sts_o.p1_pair  = p1_hi && flags_q[u8sd_pkg::FLG_SURR];
  assign sts_o.p2_undec = p2.undec;
  assign sts_o.held_v   = held_v_q;
  assign sts_o.out_free = !out_v_q || !out_stall_i;

  assign out_take = out_v_q && !out_stall_i;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    src   = '0;
    if (cmd_i.load && cnt_q < 4'(u8sd_pkg::Depth)) begin
      buf_d[cnt_q] = in_item_i.data_byte;
      cnt_d        = cnt_q + 4'd1;
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < u8sd_pkg::Depth; i++) begin
        src = 5'(i) + 5'(res_used_q);
        buf_d[i] = (src < 5'(u8sd_pkg::Depth)) ? buf_q[src[3:0]] : 8'd0;
      end
      cnt_d = cnt_q - res_used_q;
    end
    if (cmd_i.finish && fin_q) begin
      cnt_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      flags_q  <= '0;
      base_q   <= u8sd_pkg::BASE_RST;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load) begin
        fin_q <= in_item_i.end_of_data;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          u8sd_pkg::CFG_FLAGS: flags_q <= cfg_data_i[4:0];
          u8sd_pkg::CFG_BASE:  base_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        held_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        held_v_q <= 1'b0;
      end
      if ((cmd_i.commit && held_v_q) || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (out_take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (cmd_i.cap_p1) begin
      v1_q <= p1.val;
      s1_q <= p1.size;
    end
    if (cmd_i.cap_r1) begin
      res_val_q  <= r1_val;
      res_used_q <= r1_used;
    end else if (cmd_i.cap_r2) begin
      res_val_q  <= r2_val;
      res_used_q <= r2_used;
    end
    if (cmd_i.commit) begin
      held_val_q  <= res_val_q;
      held_used_q <= res_used_q;
    end
    if ((cmd_i.commit && held_v_q) || cmd_i.flush) begin
      out_q.code_point  <= held_val_q;
      out_q.bytes_used  <= held_used_q;
      out_q.last_of_run <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/u8sd_ctrl.sv */
// u8sd_ctrl: sequencing state machine of the decoder.
// Depends on u8sd_pkg.
module u8sd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  u8sd_pkg::dp_sts_t sts_i,
  output u8sd_pkg::dp_cmd_t cmd_o
);

  u8sd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u8sd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      u8sd_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = u8sd_pkg::S_P1;
        end
      end
      u8sd_pkg::S_P1: begin
        if (sts_i.p1_stop) begin
          state_d = u8sd_pkg::S_FLUSH;
        end else if (sts_i.p1_pair) begin
          cmd_o.cap_p1 = 1'b1;
          state_d      = u8sd_pkg::S_P2;
        end else begin
          cmd_o.cap_r1 = 1'b1;
          state_d      = u8sd_pkg::S_COMMIT;
        end
      end
      u8sd_pkg::S_P2: begin
        if (sts_i.p2_undec) begin
          state_d = u8sd_pkg::S_FLUSH;
        end else begin
          cmd_o.cap_r2 = 1'b1;
          state_d      = u8sd_pkg::S_COMMIT;
        end
      end
      u8sd_pkg::S_COMMIT: begin
        if (!sts_i.held_v || sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = u8sd_pkg::S_P1;
        end
      end
      u8sd_pkg::S_FLUSH: begin
        if (!sts_i.held_v) begin
          cmd_o.finish = 1'b1;
          state_d      = u8sd_pkg::S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush  = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = u8sd_pkg::S_IDLE;
        end
      end
      default: state_d = u8sd_pkg::S_IDLE;
    endcase
  end

endmodule

/* hdl/utf8_stream_decoder_core.sv */
// utf8_stream_decoder_core: top level of the byte stream to code point decoder.
// Depends on u8sd_pkg, u8sd_ctrl, u8sd_dp.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_stall_o  | in_item_i  (data_byte, end_of_data)
//   out     | output    | out_valid_o/out_stall_i| out_item_o (code_point, bytes_used, last)
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A byte that completes no item runs accept, a parse of the buffer (two if a surrogate
// pair is open), finish; each result adds a parse (two for a pair) and a commit step.
// A result is held one step so its last flag is known; the output register can still
// be waiting when the next byte is accepted. Output stalls hold the commit and flush steps.
// Reset empties the buffer; no clearing pass.
module utf8_stream_decoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [20:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u8sd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u8sd_pkg::out_item_t out_item_o
);

  u8sd_pkg::dp_cmd_t cmd;
  u8sd_pkg::dp_sts_t sts;

  u8sd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  u8sd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* hdl/u8sd_chk.sv */
// u8sd_chk: port-level checks of the decoder, bound to the top level.
// Depends on u8sd_pkg and utf8_stream_decoder_core.
module u8sd_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input u8sd_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.bytes_used != 4'd0 && out_item_o.bytes_used <= 4'd14)
    else $error("bytes_used out of range");

endmodule

bind utf8_stream_decoder_core u8sd_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
